// ===== hw/rtl/tsp_pkg.sv =====
// Shared types and constants for the texture space partials pipeline.
// No dependencies; every other file imports this package.
`default_nettype none

package tsp_pkg;

   localparam int unsigned DataW    = 32;   // Q16.16 field width
   localparam int unsigned CfgW     = 16;   // register data width
   localparam int unsigned CsrIdxW  = 8;    // register index width
   localparam int unsigned NumLanes = 6;    // dpds xyz, dpdt xyz
   localparam int unsigned QuotW    = 32;   // quotient bits before saturation
   localparam int unsigned DivSteps = QuotW;
   localparam int unsigned NumW     = 80;   // |N| * 2^16 + |D| / 2
   localparam int unsigned DenW     = 64;   // |D|
   localparam int unsigned RemW     = 96;   // partial remainder
   localparam int unsigned FW       = 65;   // sum of four squares

   localparam logic [CsrIdxW-1:0] CsrTolerance = 8'd0;
   localparam logic [CsrIdxW-1:0] CsrCondLimit = 8'd1;

   localparam logic [CfgW-1:0] TolReset  = 16'd1;
   localparam logic [CfgW-1:0] CondReset = 16'd1024;

   localparam logic [QuotW-1:0] SatPos = 32'h7FFF_FFFF;
   localparam logic [QuotW-1:0] SatNeg = 32'h8000_0000;

   typedef struct packed {
      logic signed [DataW-1:0] dpdu_x;
      logic signed [DataW-1:0] dpdu_y;
      logic signed [DataW-1:0] dpdu_z;
      logic signed [DataW-1:0] dpdv_x;
      logic signed [DataW-1:0] dpdv_y;
      logic signed [DataW-1:0] dpdv_z;
      logic signed [DataW-1:0] dtdu_s;
      logic signed [DataW-1:0] dtdu_t;
      logic signed [DataW-1:0] dtdv_s;
      logic signed [DataW-1:0] dtdv_t;
   } tsp_req_type;

   typedef struct packed {
      logic signed [DataW-1:0] dpds_x;
      logic signed [DataW-1:0] dpds_y;
      logic signed [DataW-1:0] dpds_z;
      logic signed [DataW-1:0] dpdt_x;
      logic signed [DataW-1:0] dpdt_y;
      logic signed [DataW-1:0] dpdt_z;
      logic                    well_conditioned;
   } tsp_rsp_type;

   // Front end to divider lanes
   typedef struct packed {
      logic                               ok;
      logic [NumLanes-1:0]                neg;
      logic [NumLanes-1:0]                ovf;
      logic [NumLanes-1:0][NumW-1:0]      num;
      logic [DenW-1:0]                    den;
   } tsp_div_req_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tsp_front.sv =====
// Front end: products, determinant, conditioning tests and dividends (5 stages).
// Depends on tsp_pkg.
`default_nettype none

module tsp_front import tsp_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  wire tsp_req_type     in_data,
   input  wire logic [CfgW-1:0] tol,
   input  wire logic [CfgW-1:0] lim,
   output logic                 out_valid,
   output tsp_req_type          out_data,
   output tsp_div_req_type      out_div
);

   // ---------------- stage 1: raw products ----------------
   logic signed [63:0]   ad_in, bc_in, ad_ff, bc_ff;
   logic signed [63:0]   sq_in [4];
   logic signed [63:0]   sq_ff [4];
   logic signed [63:0]   npa_in [NumLanes];
   logic signed [63:0]   npb_in [NumLanes];
   logic signed [63:0]   npa_ff [NumLanes];
   logic signed [63:0]   npb_ff [NumLanes];
   logic [31:0]          t2_in, t2_1_ff;
   logic [32:0]          l2p1_in, l2p1_1_ff;
   logic [31:0]          tolsh_in, tolsh_1_ff;
   logic                 limbad_in, limbad_1_ff;
   logic [CfgW-1:0]      lim_1_ff;
   tsp_req_type          data_1_ff;
   logic                 vld_1_ff;

   always_comb begin
      logic signed [DataW-1:0] pu [3];
      logic signed [DataW-1:0] pv [3];
      logic signed [DataW-1:0] a, b, c, d;
      pu[0] = in_data.dpdu_x;
      pu[1] = in_data.dpdu_y;
      pu[2] = in_data.dpdu_z;
      pv[0] = in_data.dpdv_x;
      pv[1] = in_data.dpdv_y;
      pv[2] = in_data.dpdv_z;
      a = in_data.dtdu_s;
      b = in_data.dtdu_t;
      c = in_data.dtdv_s;
      d = in_data.dtdv_t;
      ad_in = $signed(a) * $signed(d);
      bc_in = $signed(b) * $signed(c);
      sq_in[0] = $signed(a) * $signed(a);
      sq_in[1] = $signed(b) * $signed(b);
      sq_in[2] = $signed(c) * $signed(c);
      sq_in[3] = $signed(d) * $signed(d);
      for (int k = 0; k < 3; k++) begin
         npa_in[k]     = $signed(pu[k]) * $signed(d);
         npb_in[k]     = $signed(pv[k]) * $signed(b);
         npa_in[k + 3] = $signed(pv[k]) * $signed(a);
         npb_in[k + 3] = $signed(pu[k]) * $signed(c);
      end
      t2_in     = tol * tol;
      l2p1_in   = lim * lim + 33'd1;
      tolsh_in  = {tol, 16'h0000};
      limbad_in = (lim <= 16'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_1_ff <= 1'b0;
      end else if (en) begin
         vld_1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ad_ff       <= ad_in;
         bc_ff       <= bc_in;
         sq_ff       <= sq_in;
         npa_ff      <= npa_in;
         npb_ff      <= npb_in;
         t2_1_ff     <= t2_in;
         l2p1_1_ff   <= l2p1_in;
         tolsh_1_ff  <= tolsh_in;
         limbad_1_ff <= limbad_in;
         lim_1_ff    <= lim;
         data_1_ff   <= in_data;
      end
   end

   // ---------------- stage 2: |D|, F, numerators ----------------
   logic [DenW-1:0]      dm_in, dm_2_ff;
   logic                 dneg_in, dneg_2_ff;
   logic [FW-1:0]        f_in, f_2_ff;
   logic [63:0]          nmag_in [NumLanes];
   logic [63:0]          nmag_ff [NumLanes];
   logic [NumLanes-1:0]  nneg_in, nneg_ff;
   logic [31:0]          t2_2_ff;
   logic [32:0]          l2p1_2_ff;
   logic [31:0]          tolsh_2_ff;
   logic                 limbad_2_ff;
   logic [CfgW-1:0]      lim_2_ff;
   tsp_req_type          data_2_ff;
   logic                 vld_2_ff;

   always_comb begin
      logic signed [64:0] diff;
      logic [64:0]        amag;
      diff    = 65'(ad_ff) - 65'(bc_ff);
      dneg_in = diff[64];
      amag    = dneg_in ? -diff : diff;
      dm_in   = amag[63:0];
      f_in    = FW'($unsigned(sq_ff[0])) + FW'($unsigned(sq_ff[1]))
              + FW'($unsigned(sq_ff[2])) + FW'($unsigned(sq_ff[3]));
      for (int k = 0; k < NumLanes; k++) begin
         diff       = 65'(npa_ff[k]) - 65'(npb_ff[k]);
         nneg_in[k] = diff[64];
         amag       = nneg_in[k] ? -diff : diff;
         nmag_in[k] = amag[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_2_ff <= 1'b0;
      end else if (en) begin
         vld_2_ff <= vld_1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dm_2_ff     <= dm_in;
         dneg_2_ff   <= dneg_in;
         f_2_ff      <= f_in;
         nmag_ff     <= nmag_in;
         nneg_ff     <= nneg_in;
         t2_2_ff     <= t2_1_ff;
         l2p1_2_ff   <= l2p1_1_ff;
         tolsh_2_ff  <= tolsh_1_ff;
         limbad_2_ff <= limbad_1_ff;
         lim_2_ff    <= lim_1_ff;
         data_2_ff   <= data_1_ff;
      end
   end

   // ---------------- stage 3: partial products, dividends ----------------
   logic [63:0]               ddhh_in, ddhl_in, ddll_in, ddhh_ff, ddhl_ff, ddll_ff;
   logic [63:0]               ftlo_in, ftlo_ff, tt_in, tt_ff;
   logic [64:0]               fthi_in, fthi_ff;
   logic [80:0]               lf_in, lf_3_ff;
   logic [64:0]               ldlo_in, ldhi_in, ldlo_ff, ldhi_ff;
   logic                      bada_in, badb_in, bada_ff, badb_ff;
   logic [NumW-1:0]           num_in [NumLanes];
   logic [NumW-1:0]           num_3_ff [NumLanes];
   logic [NumLanes-1:0]       neg_in, neg_3_ff;
   logic [DenW-1:0]           dm_3_ff;
   tsp_req_type               data_3_ff;
   logic                      vld_3_ff;

   always_comb begin
      ddhh_in = dm_2_ff[63:32] * dm_2_ff[63:32];
      ddhl_in = dm_2_ff[63:32] * dm_2_ff[31:0];
      ddll_in = dm_2_ff[31:0] * dm_2_ff[31:0];
      ftlo_in = f_2_ff[31:0] * t2_2_ff;
      fthi_in = f_2_ff[64:32] * t2_2_ff;
      tt_in   = t2_2_ff * t2_2_ff;
      lf_in   = f_2_ff * lim_2_ff;
      ldlo_in = l2p1_2_ff * dm_2_ff[31:0];
      ldhi_in = l2p1_2_ff * dm_2_ff[63:32];
      bada_in = (dm_2_ff == '0) || limbad_2_ff || (dm_2_ff < DenW'(tolsh_2_ff));
      badb_in = (FW'({t2_2_ff, 1'b0}) >= f_2_ff);
      for (int k = 0; k < NumLanes; k++) begin
         num_in[k] = {nmag_ff[k], 16'h0000} + NumW'(dm_2_ff >> 1);
         neg_in[k] = nneg_ff[k] ^ dneg_2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_3_ff <= 1'b0;
      end else if (en) begin
         vld_3_ff <= vld_2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ddhh_ff   <= ddhh_in;
         ddhl_ff   <= ddhl_in;
         ddll_ff   <= ddll_in;
         ftlo_ff   <= ftlo_in;
         fthi_ff   <= fthi_in;
         tt_ff     <= tt_in;
         lf_3_ff   <= lf_in;
         ldlo_ff   <= ldlo_in;
         ldhi_ff   <= ldhi_in;
         bada_ff   <= bada_in;
         badb_ff   <= badb_in;
         num_3_ff  <= num_in;
         neg_3_ff  <= neg_in;
         dm_3_ff   <= dm_2_ff;
         data_3_ff <= data_2_ff;
      end
   end

   // ---------------- stage 4: wide sums, overflow checks ----------------
   logic [127:0]         lhs_in, rhs_in, lhs_ff, rhs_ff;
   logic [97:0]          ld_in, ld_ff;
   logic [80:0]          lf_4_ff;
   logic                 bad_in, bad_ff;
   logic [NumLanes-1:0]  ovf_in, ovf_4_ff, neg_4_ff;
   logic [NumW-1:0]      num_4_ff [NumLanes];
   logic [DenW-1:0]      dm_4_ff;
   tsp_req_type          data_4_ff;
   logic                 vld_4_ff;

   always_comb begin
      // T^2 + D^2 against F*T + 1
      lhs_in = 128'(tt_ff) + (128'(ddhh_ff) << 64) + (128'(ddhl_ff) << 33) + 128'(ddll_ff);
      rhs_in = (128'(fthi_ff) << 32) + 128'(ftlo_ff) + 128'd1;
      ld_in  = (98'(ldhi_ff) << 32) + 98'(ldlo_ff);
      bad_in = bada_ff || badb_ff;
      // quotient of 2^32 or more saturates
      for (int k = 0; k < NumLanes; k++) begin
         ovf_in[k] = (RemW'(num_3_ff[k]) >= {dm_3_ff, 32'h0000_0000});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_4_ff <= 1'b0;
      end else if (en) begin
         vld_4_ff <= vld_3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lhs_ff    <= lhs_in;
         rhs_ff    <= rhs_in;
         ld_ff     <= ld_in;
         lf_4_ff   <= lf_3_ff;
         bad_ff    <= bad_in;
         ovf_4_ff  <= ovf_in;
         neg_4_ff  <= neg_3_ff;
         num_4_ff  <= num_3_ff;
         dm_4_ff   <= dm_3_ff;
         data_4_ff <= data_3_ff;
      end
   end

   // ---------------- stage 5: final verdict ----------------
   logic            ok_in;
   tsp_div_req_type div_ff;
   tsp_req_type     data_5_ff;
   logic            vld_5_ff;

   always_comb begin
      ok_in = !bad_ff && (lhs_ff >= rhs_ff) && !(98'(lf_4_ff) >= ld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_5_ff <= 1'b0;
      end else if (en) begin
         vld_5_ff <= vld_4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_5_ff  <= data_4_ff;
         div_ff.ok  <= ok_in;
         div_ff.ovf <= ovf_4_ff;
         div_ff.neg <= neg_4_ff;
         div_ff.den <= dm_4_ff;
         for (int k = 0; k < NumLanes; k++) begin
            div_ff.num[k] <= num_4_ff[k];
         end
      end
   end

   assign out_div   = div_ff;
   assign out_valid = vld_5_ff;
   assign out_data  = data_5_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tsp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage (QuotW stages).
// Depends on tsp_pkg.
`default_nettype none

module tsp_div import tsp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [NumW-1:0]   num,
   input  wire logic [DenW-1:0]   den,
   input  wire logic              neg,
   input  wire logic              ovf,
   output logic [QuotW-1:0]       q,
   output logic                   q_neg,
   output logic                   q_ovf
);

   logic [RemW-1:0]     rem_ff [DivSteps];
   logic [DenW-1:0]     den_ff [DivSteps];
   logic [QuotW-1:0]    q_ff   [DivSteps];
   logic [DivSteps-1:0] neg_ff, ovf_ff;

   for (genvar k = 0; k < DivSteps; k++) begin : g_step
      localparam int unsigned Shift = QuotW - 1 - k;
      logic [RemW-1:0]  rem_src, rem_in;
      logic [DenW-1:0]  den_src;
      logic [QuotW-1:0] q_src, q_in;
      logic             neg_src, ovf_src, take;
      logic [RemW:0]    den_sh, trial;

      if (k == 0) begin : g_first
         assign rem_src = RemW'(num);
         assign den_src = den;
         assign q_src   = '0;
         assign neg_src = neg;
         assign ovf_src = ovf;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign q_src   = q_ff[k-1];
         assign neg_src = neg_ff[k-1];
         assign ovf_src = ovf_ff[k-1];
      end

      always_comb begin
         den_sh = (RemW+1)'(den_src) << Shift;
         trial  = {1'b0, rem_src} - den_sh;
         take   = !trial[RemW];
         rem_in = take ? trial[RemW-1:0] : rem_src;
         q_in   = {q_src[QuotW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src;
            q_ff[k]   <= q_in;
            neg_ff[k] <= neg_src;
            ovf_ff[k] <= ovf_src;
         end
      end
   end

   assign q     = q_ff[DivSteps-1];
   assign q_neg = neg_ff[DivSteps-1];
   assign q_ovf = ovf_ff[DivSteps-1];

endmodule

`default_nettype wire

// ===== hw/rtl/texture_space_partials_core.sv =====
// Texture space partials: maps dP/du, dP/dv through the inverse texture Jacobian.
// Depends on tsp_pkg, tsp_front and tsp_div.
//
// Usage:
//   Request channel (req_valid / req_stall / req_data) takes one item of surface
//   and texture derivatives per cycle unless stalled. Response channel
//   (rsp_valid / rsp_stall / rsp_data) returns dP/ds, dP/dt and well_conditioned
//   in request order. Register port (csr_valid / csr_ready / csr_index /
//   csr_wdata) is always ready; index 0 is tolerance_lsb, index 1 is cond_limit,
//   others are ignored.
// Stages: 5 front-end (products, determinant, conditioning tests), 32 divider
//   (one quotient bit each, six lanes in parallel) and the output register.
// Throughput: one request per cycle, sustained while no response is stalled.
// Stall: while a response is held by rsp_stall the whole pipeline freezes and
//   req_stall is raised; nothing is dropped or repeated.
// Reset: clears all valid bits and sets tolerance_lsb to 1, cond_limit to 1024.
`default_nettype none

module texture_space_partials_core import tsp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire tsp_req_type        req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output tsp_rsp_type             rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CsrIdxW-1:0] csr_index,
   input  wire logic [CfgW-1:0]    csr_wdata
);

   logic [CfgW-1:0] tol_ff, lim_ff;
   logic            adv;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TolReset;
         lim_ff <= CondReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrTolerance: tol_ff <= csr_wdata;
            CsrCondLimit: lim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // advance everything unless the output register is held
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   logic            f_vld;
   tsp_req_type     f_data;
   tsp_div_req_type f_div;

   tsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .tol       (tol_ff),
      .lim       (lim_ff),
      .out_valid (f_vld),
      .out_data  (f_data),
      .out_div   (f_div)
   );

   logic [QuotW-1:0]    dq [NumLanes];
   logic [NumLanes-1:0] dneg, dovf;

   for (genvar k = 0; k < NumLanes; k++) begin : g_lane
      tsp_div u_div (
         .clock (clock),
         .en    (adv),
         .num   (f_div.num[k]),
         .den   (f_div.den),
         .neg   (f_div.neg[k]),
         .ovf   (f_div.ovf[k]),
         .q     (dq[k]),
         .q_neg (dneg[k]),
         .q_ovf (dovf[k])
      );
   end

   // side line: valid, verdict and fallback values alongside the divider
   logic [DivSteps-1:0] dvld_ff, dok_ff;
   tsp_req_type         dpay_ff [DivSteps];

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff <= '0;
      end else if (adv) begin
         dvld_ff <= {dvld_ff[DivSteps-2:0], f_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dok_ff     <= {dok_ff[DivSteps-2:0], f_div.ok};
         dpay_ff[0] <= f_data;
         for (int k = 1; k < DivSteps; k++) begin
            dpay_ff[k] <= dpay_ff[k-1];
         end
      end
   end

   // round already folded into the dividend; saturate and apply sign
   logic [DataW-1:0] res [NumLanes];
   tsp_rsp_type      rsp_in, rsp_data_ff;

   always_comb begin
      logic [QuotW-1:0] lim_q, mag;
      tsp_req_type      pay;
      for (int k = 0; k < NumLanes; k++) begin
         lim_q  = dneg[k] ? SatNeg : SatPos;
         mag    = (dovf[k] || (dq[k] > lim_q)) ? lim_q : dq[k];
         res[k] = dneg[k] ? -mag : mag;
      end
      pay = dpay_ff[DivSteps-1];
      if (dok_ff[DivSteps-1]) begin
         rsp_in.dpds_x = res[0];
         rsp_in.dpds_y = res[1];
         rsp_in.dpds_z = res[2];
         rsp_in.dpdt_x = res[3];
         rsp_in.dpdt_y = res[4];
         rsp_in.dpdt_z = res[5];
         rsp_in.well_conditioned = 1'b1;
      end else begin
         rsp_in.dpds_x = pay.dpdu_x;
         rsp_in.dpds_y = pay.dpdu_y;
         rsp_in.dpds_z = pay.dpdu_z;
         rsp_in.dpdt_x = pay.dpdv_x;
         rsp_in.dpdt_y = pay.dpdv_y;
         rsp_in.dpdt_z = pay.dpdv_z;
         rsp_in.well_conditioned = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dvld_ff[DivSteps-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an accepted Jacobian never has a zero determinant
   a_ok_nonzero_den: assert property (@(posedge clock) disable iff (reset)
      (f_vld && f_div.ok) |-> (f_div.den != '0))
      else $error("well conditioned request with zero determinant");

   // register write lands in the next cycle
   a_tol_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index == CsrTolerance) |=>
      (tol_ff == $past(csr_wdata)))
      else $error("tolerance write lost");

   // frozen pipeline keeps its occupancy
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(dvld_ff))
      else $error("divider valid bits moved while stalled");

endmodule

`default_nettype wire
